@@ rtl/core/pn3_pkg.sv @@
// Shared types, constants and arithmetic helpers for the 3D noise core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pn3_pkg;
  localparam int TableSize = 256;
  localparam int IdxW = $clog2(TableSize);
  localparam int OutW = 18;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  typedef enum logic {
    OpLoad = 1'b0,
    OpEval = 1'b1
  } op_e;

  typedef struct packed {
    logic [IdxW-1:0] xi;
    logic [IdxW-1:0] yi;
    logic [IdxW-1:0] zi;
    logic [15:0]     fx;
    logic [15:0]     fy;
    logic [15:0]     fz;
  } eval_req_t;

  function automatic logic signed [18:0] grad(input logic [3:0] h,
                                              input logic signed [17:0] x,
                                              input logic signed [17:0] y,
                                              input logic signed [17:0] z);
    logic signed [17:0] u;
    logic signed [17:0] v;
    logic signed [18:0] su;
    logic signed [18:0] sv;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    su = h[0] ? -19'(u) : 19'(u);
    sv = h[1] ? -19'(v) : 19'(v);
    return su + sv;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/perlin_noise_3d_core.sv @@
// Top level of the 3D gradient noise core: front end, request queue, back-end pipeline.
// Depends on pn3_pkg, pn3_front and pn3_back.
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake          | Payload
// input    | valid_i / ready_o  | op, table_index, table_value, coord_x/y/z
// output   | valid_o / ready_i  | noise_value
// One request per cycle is accepted while ready_o is high; an evaluation's result is presented
// after it passes through the queue and then the eleven-stage back-end pipeline.
// A load gives no result; it waits until no evaluation is in flight.
// Reset clears the queue and pipeline valid bits; the table is undefined until loaded.
// An output stall freezes the pipeline; the four-entry queue absorbs requests meanwhile.
module perlin_noise_3d_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  table_index_i,
  input  wire logic [7:0]  table_value_i,
  input  wire logic [31:0] coord_x_i,
  input  wire logic [31:0] coord_y_i,
  input  wire logic [31:0] coord_z_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [17:0]      noise_value_o
);
  import pn3_pkg::*;

  logic            wr_en, q_valid, q_ready, busy;
  logic [IdxW-1:0] wr_addr;
  logic [7:0]      wr_data;
  eval_req_t       q_data;

  pn3_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .op_i, .table_index_i, .table_value_i,
    .coord_x_i, .coord_y_i, .coord_z_i, .busy_i(busy),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  pn3_back u_back (
    .clk_i, .rst_ni,
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_data_i(q_data),
    .busy_o(busy), .valid_o, .ready_i, .noise_value_o
  );
endmodule
`default_nettype wire

@@ rtl/core/pn3_front.sv @@
// Front end: accepts requests, writes the table on loads, and queues evaluations.
// Depends on pn3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pn3_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire logic                op_i,
  input  wire logic [7:0]          table_index_i,
  input  wire logic [7:0]          table_value_i,
  input  wire logic [31:0]         coord_x_i,
  input  wire logic [31:0]         coord_y_i,
  input  wire logic [31:0]         coord_z_i,
  input  wire logic                busy_i,
  output logic                     wr_en_o,
  output logic [pn3_pkg::IdxW-1:0] wr_addr_o,
  output logic [7:0]               wr_data_o,
  output logic                     q_valid_o,
  input  wire logic                q_ready_i,
  output pn3_pkg::eval_req_t       q_data_o
);
  import pn3_pkg::*;

  eval_req_t             mem_q [QDepth];
  logic [QPtrW-1:0]      wp_q, wp_d, rp_q, rp_d;
  logic [QPtrW:0]        cnt_q, cnt_d;
  logic                  push, pop;
  eval_req_t             in_req;

  // A load waits until no evaluation is queued or in the pipeline.
  assign ready_o = (op_e'(op_i) == OpLoad) ? ((cnt_q == '0) && !busy_i)
                                           : (cnt_q != (QPtrW+1)'(QDepth));
  assign push = valid_i && ready_o && (op_e'(op_i) == OpEval);
  assign pop = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o = mem_q[rp_q];

  assign wr_en_o = valid_i && ready_o && (op_e'(op_i) == OpLoad);
  assign wr_addr_o = table_index_i[IdxW-1:0];
  assign wr_data_o = table_value_i;

  always_comb begin
    in_req.xi = coord_x_i[16 +: IdxW];
    in_req.yi = coord_y_i[16 +: IdxW];
    in_req.zi = coord_z_i[16 +: IdxW];
    in_req.fx = coord_x_i[15:0];
    in_req.fy = coord_y_i[15:0];
    in_req.fz = coord_z_i[15:0];
    wp_d = push ? wp_q + 1'b1 : wp_q;
    rp_d = pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/pn3_back.sv @@
// Back end: pipelined hash lookups, fade curves, gradients and trilinear blend.
// Depends on pn3_pkg. The lookup stages read their own copies of the table.
`timescale 1ns / 1ps
`default_nettype none
module pn3_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [pn3_pkg::IdxW-1:0] wr_addr_i,
  input  wire logic [7:0]          wr_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  pn3_pkg::eval_req_t       in_data_i,
  output logic                     busy_o,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output logic [pn3_pkg::OutW-1:0] noise_value_o
);
  import pn3_pkg::*;

  localparam int NStg = 11;

  logic [NStg-1:0] v_q;

  // Stall-all pipeline: advance when output free.
  logic adv;
  assign adv = !v_q[NStg-1] || ready_i;
  assign in_ready_o = adv;
  assign valid_o = v_q[NStg-1];
  assign busy_o = |v_q;

  // Replicated tables, each copy read at no more than two addresses.
  logic [7:0] t1_q [TableSize];
  logic [7:0] t2_q [2][TableSize];
  logic [7:0] t3_q [4][TableSize];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      t1_q[wr_addr_i] <= wr_data_i;
      for (int k = 0; k < 2; k++) begin
        t2_q[k][wr_addr_i] <= wr_data_i;
      end
      for (int k = 0; k < 4; k++) begin
        t3_q[k][wr_addr_i] <= wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NStg-2:0], in_valid_i};
    end
  end

  // Stage 1: read perm[xi], perm[xi+1]; fade squares.
  eval_req_t      r1_q;
  logic [7:0]     pa_q, pb_q;
  logic [31:0]    sx_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_q <= in_data_i;
      pa_q <= t1_q[in_data_i.xi];
      pb_q <= t1_q[in_data_i.xi + 1'b1];
      sx_q[0] <= 32'(in_data_i.fx) * 32'(in_data_i.fx);
      sx_q[1] <= 32'(in_data_i.fy) * 32'(in_data_i.fy);
      sx_q[2] <= 32'(in_data_i.fz) * 32'(in_data_i.fz);
    end
  end

  // Stage 2: a0, b0 lookups; t3 and q.
  eval_req_t   r2_q;
  logic [7:0]  pa0_q, pa01_q, pb0_q, pb01_q;
  logic [31:0] cu_q [3];
  logic [19:0] qq_q [3];
  logic [15:0] f1 [3];
  logic [IdxW-1:0] a0, b0;
  assign f1[0] = r1_q.fx;
  assign f1[1] = r1_q.fy;
  assign f1[2] = r1_q.fz;
  assign a0 = pa_q + r1_q.yi;
  assign b0 = pb_q + r1_q.yi;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_q <= r1_q;
      pa0_q <= t2_q[0][a0];
      pa01_q <= t2_q[0][a0 + 1'b1];
      pb0_q <= t2_q[1][b0];
      pb01_q <= t2_q[1][b0 + 1'b1];
      for (int i = 0; i < 3; i++) begin
        cu_q[i] <= 32'((48'(sx_q[i]) * 48'(f1[i])) >> 16);
        qq_q[i] <= 20'((36'(sx_q[i]) * 36'd6 + (36'd10 << 32)
                       - (36'(f1[i]) * 36'd15 << 16)) >> 16);
      end
    end
  end

  // Stage 3: corner hash lookups; fade product.
  eval_req_t   r3_q;
  logic [3:0]  h_q [8];
  logic [51:0] fp_q [3];
  logic [IdxW-1:0] hidx [8];
  always_comb begin
    hidx[0] = pa0_q + r2_q.zi;
    hidx[2] = pa01_q + r2_q.zi;
    hidx[1] = pb0_q + r2_q.zi;
    hidx[3] = pb01_q + r2_q.zi;
    for (int i = 0; i < 4; i++) begin
      hidx[i+4] = hidx[i] + 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r3_q <= r2_q;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= t3_q[i%4][hidx[i]][3:0];
      end
      for (int i = 0; i < 3; i++) begin
        fp_q[i] <= cu_q[i] * qq_q[i];
      end
    end
  end

  // Stage 4: gradients and fade weights.
  logic signed [18:0] g_q [8];
  logic signed [17:0] w4_q [3];
  logic signed [17:0] ox [2], oy [2], oz [2];
  assign ox[0] = 18'(r3_q.fx);
  assign ox[1] = 18'(r3_q.fx) - 18'sd65536;
  assign oy[0] = 18'(r3_q.fy);
  assign oy[1] = 18'(r3_q.fy) - 18'sd65536;
  assign oz[0] = 18'(r3_q.fz);
  assign oz[1] = 18'(r3_q.fz) - 18'sd65536;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) begin
        g_q[i] <= grad(h_q[i], ox[i%2], oy[(i/2)%2], oz[i/4]);
      end
      for (int i = 0; i < 3; i++) begin
        w4_q[i] <= 18'((53'(fp_q[i]) + 53'h80000000) >> 32);
      end
    end
  end

  // Stages 5..10: three lerp levels, each multiply then add; a final stage then saturates the result.
  logic signed [37:0] m1_q [4];
  logic signed [18:0] a1_q [4];
  logic signed [17:0] w5_q [2];
  logic signed [19:0] l1_q [4];
  logic signed [17:0] w6_q [2];
  logic signed [38:0] m2_q [2];
  logic signed [19:0] a2_q [2];
  logic signed [17:0] w7_q;
  logic signed [20:0] l2_q [2];
  logic signed [17:0] w8_q;
  logic signed [39:0] m3_q;
  logic signed [20:0] a3_q;
  logic signed [21:0] l3_q;
  logic [OutW-1:0]    out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        m1_q[i] <= 38'(20'(g_q[2*i+1]) - 20'(g_q[2*i])) * 38'(w4_q[0]);
        a1_q[i] <= g_q[2*i];
      end
      w5_q[0] <= w4_q[1];
      w5_q[1] <= w4_q[2];
      for (int i = 0; i < 4; i++) begin
        l1_q[i] <= 20'(a1_q[i]) + 20'((m1_q[i] + 38'sd32768) >>> 16);
      end
      w6_q <= w5_q;
      for (int i = 0; i < 2; i++) begin
        m2_q[i] <= 39'(21'(l1_q[2*i+1]) - 21'(l1_q[2*i])) * 39'(w6_q[0]);
        a2_q[i] <= l1_q[2*i];
      end
      w7_q <= w6_q[1];
      for (int i = 0; i < 2; i++) begin
        l2_q[i] <= 21'(a2_q[i]) + 21'((m2_q[i] + 39'sd32768) >>> 16);
      end
      w8_q <= w7_q;
      m3_q <= 40'(22'(l2_q[1]) - 22'(l2_q[0])) * 40'(w8_q);
      a3_q <= l2_q[0];
      l3_q <= 22'(a3_q) + 22'((m3_q + 40'sd32768) >>> 16);
      if (l3_q > 22'sd131071) begin
        out_q <= 18'h1FFFF;
      end else if (l3_q < -22'sd131072) begin
        out_q <= 18'h20000;
      end else begin
        out_q <= l3_q[OutW-1:0];
      end
    end
  end

  assign noise_value_o = out_q;
endmodule
`default_nettype wire
